### rtl/mtep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  key_or_number;
    logic [7:0]  value;
    logic [13:0] bend;
    logic [23:0] meta_value;
    logic [31:0] delta_ticks;
  } out_item_t;

  localparam logic [3:0] KIND_OFF       = 4'd0;
  localparam logic [3:0] KIND_ON        = 4'd1;
  localparam logic [3:0] KIND_KEYPRESS  = 4'd2;
  localparam logic [3:0] KIND_CTRL      = 4'd3;
  localparam logic [3:0] KIND_PROG      = 4'd4;
  localparam logic [3:0] KIND_CHANPRESS = 4'd5;
  localparam logic [3:0] KIND_BEND      = 4'd6;
  localparam logic [3:0] KIND_SYSEX     = 4'd7;
  localparam logic [3:0] KIND_EOT       = 4'd8;
  localparam logic [3:0] KIND_TEMPO     = 4'd9;
  localparam logic [3:0] KIND_TIMESIG   = 4'd10;
  localparam logic [3:0] KIND_PORT      = 4'd11;
  localparam logic [3:0] KIND_META      = 4'd12;
  localparam logic [3:0] KIND_OTHER     = 4'd13;

  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_PORT    = 8'h21;

  localparam int QDEPTH = 2;

endpackage
`default_nettype wire

### rtl/mtep_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front: per-byte parser. Emits one finished event per byte at most.
module mtep_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire mtep_pkg::in_item_t  in_item,
  output logic                     ev_valid,
  output mtep_pkg::out_item_t      ev_item
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SX_LEN, PH_SX_BODY,
    PH_META_TYPE, PH_META_LEN, PH_META_BODY
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [7:0]  running_status, running_status_next, rs;
  logic [7:0]  current_status, current_status_next;
  logic [31:0] delta_accum, delta_accum_next, da;
  logic [31:0] body_remaining, body_remaining_next, br;
  logic [7:0]  meta_type, meta_type_next;
  logic [7:0]  first_data, first_data_next;
  logic [23:0] meta_accum, meta_accum_next;
  logic [2:0]  meta_index, meta_index_next;

  logic [7:0]  b;
  logic        emit;
  mtep_pkg::out_item_t ev;
  logic [31:0] len_acc;
  logic [31:0] br_dec;

  function automatic mtep_pkg::out_item_t chan_ev(input logic [7:0] st,
      input logic [7:0] d1, input logic [7:0] d2, input logic [31:0] dt);
    mtep_pkg::out_item_t e;
    logic [3:0] ch;
    logic [6:0] k;
    logic [6:0] v;
    e = '0;
    ch = st[3:0];
    k = d1[6:0];
    v = d2[6:0];
    e.channel = ch;
    e.delta_ticks = dt;
    case (st[7:4])
      4'h8: begin
        e.event_kind = mtep_pkg::KIND_OFF; e.key_or_number = k; e.value = {1'b0, v};
      end
      4'h9: begin
        e.event_kind = (v != 7'd0) ? mtep_pkg::KIND_ON : mtep_pkg::KIND_OFF;
        e.key_or_number = k; e.value = {1'b0, v};
      end
      4'hA: begin
        e.event_kind = mtep_pkg::KIND_KEYPRESS; e.key_or_number = k; e.value = {1'b0, v};
      end
      4'hB: begin
        e.event_kind = mtep_pkg::KIND_CTRL; e.key_or_number = k; e.value = {1'b0, v};
      end
      4'hC: begin
        e.event_kind = mtep_pkg::KIND_PROG;
        e.value = {(ch == 4'd9), k};
      end
      4'hD: begin
        e.event_kind = mtep_pkg::KIND_CHANPRESS; e.value = d1;
      end
      default: begin
        e.event_kind = mtep_pkg::KIND_BEND; e.bend = {v, k};
      end
    endcase
    return e;
  endfunction

  function automatic mtep_pkg::out_item_t meta_ev(input logic [7:0] mt,
      input logic [23:0] acc, input logic [31:0] dt);
    mtep_pkg::out_item_t e;
    e = '0;
    e.key_or_number = mt[6:0];
    e.delta_ticks = dt;
    case (mt)
      mtep_pkg::META_EOT:     e.event_kind = mtep_pkg::KIND_EOT;
      mtep_pkg::META_TEMPO:   begin e.event_kind = mtep_pkg::KIND_TEMPO; e.meta_value = acc; end
      mtep_pkg::META_TIMESIG: begin e.event_kind = mtep_pkg::KIND_TIMESIG; e.meta_value = acc; end
      mtep_pkg::META_PORT:    begin e.event_kind = mtep_pkg::KIND_PORT; e.meta_value = acc; end
      default:                e.event_kind = mtep_pkg::KIND_META;
    endcase
    return e;
  endfunction

  always_comb begin
    b  = in_item.data_byte;
    ph = in_item.track_start ? PH_DELTA : phase;
    rs = in_item.track_start ? 8'd0 : running_status;
    da = in_item.track_start ? 32'd0 : delta_accum;
    br = in_item.track_start ? 32'd0 : body_remaining;

    phase_next          = ph;
    running_status_next = rs;
    current_status_next = in_item.track_start ? 8'd0 : current_status;
    delta_accum_next    = da;
    body_remaining_next = br;
    meta_type_next      = in_item.track_start ? 8'd0 : meta_type;
    first_data_next     = in_item.track_start ? 8'd0 : first_data;
    meta_accum_next     = in_item.track_start ? 24'd0 : meta_accum;
    meta_index_next     = in_item.track_start ? 3'd0 : meta_index;
    emit = 1'b0;
    ev   = '0;
    ev.delta_ticks = da;
    len_acc = {br[24:0], 7'd0} + {25'd0, b[6:0]};
    br_dec  = br - 32'd1;

    case (ph)
      PH_STATUS: begin
        current_status_next = b;
        if (!b[7]) begin
          if (rs != 8'd0) begin
            current_status_next = rs;
            first_data_next = b;
            if (rs[7:4] == 4'hC || rs[7:4] == 4'hD) begin
              emit = 1'b1;
              ev = chan_ev(rs, b, 8'd0, da);
            end else begin
              phase_next = PH_DATA2;
            end
          end else begin
            emit = 1'b1;
            ev.event_kind = mtep_pkg::KIND_OTHER;
          end
        end else if (b[7:4] != 4'hF) begin
          running_status_next = b;
          phase_next = PH_DATA1;
        end else if (b == 8'hF0 || b == 8'hF7) begin
          running_status_next = 8'd0;
          body_remaining_next = 32'd0;
          phase_next = PH_SX_LEN;
        end else if (b == 8'hFF) begin
          phase_next = PH_META_TYPE;
        end else begin
          emit = 1'b1;
          ev.event_kind = mtep_pkg::KIND_OTHER;
        end
      end
      PH_DATA1: begin
        first_data_next = b;
        if (current_status[7:4] == 4'hC || current_status[7:4] == 4'hD) begin
          emit = 1'b1;
          ev = chan_ev(current_status, b, 8'd0, da);
        end else begin
          phase_next = PH_DATA2;
        end
      end
      PH_DATA2: begin
        emit = 1'b1;
        ev = chan_ev(current_status, first_data, b, da);
      end
      PH_SX_LEN: begin
        body_remaining_next = len_acc;
        if (!b[7]) begin
          if (len_acc == 32'd0) begin
            emit = 1'b1;
            ev.event_kind = mtep_pkg::KIND_SYSEX;
          end else begin
            phase_next = PH_SX_BODY;
          end
        end
      end
      PH_SX_BODY: begin
        body_remaining_next = br_dec;
        if (br_dec == 32'd0) begin
          emit = 1'b1;
          ev.event_kind = mtep_pkg::KIND_SYSEX;
        end
      end
      PH_META_TYPE: begin
        meta_type_next = b;
        body_remaining_next = 32'd0;
        meta_accum_next = 24'd0;
        meta_index_next = 3'd0;
        phase_next = PH_META_LEN;
      end
      PH_META_LEN: begin
        body_remaining_next = len_acc;
        if (!b[7]) begin
          if (len_acc == 32'd0) begin
            emit = 1'b1;
            ev = meta_ev(meta_type, meta_accum, da);
          end else begin
            phase_next = PH_META_BODY;
          end
        end
      end
      PH_META_BODY: begin
        if (meta_type == mtep_pkg::META_TEMPO && meta_index < 3'd3)
          meta_accum_next = {meta_accum[15:0], b};
        else if (meta_type == mtep_pkg::META_TIMESIG && meta_index == 3'd2)
          meta_accum_next = {16'd0, b};
        else if (meta_type == mtep_pkg::META_PORT && meta_index == 3'd0)
          meta_accum_next = {16'd0, b};
        if (meta_index != 3'd7)
          meta_index_next = meta_index + 3'd1;
        body_remaining_next = br_dec;
        if (br_dec == 32'd0) begin
          emit = 1'b1;
          ev = meta_ev(meta_type, meta_accum_next, da);
        end
      end
      default: begin
        delta_accum_next = {da[24:0], 7'd0} + {25'd0, b[6:0]};
        phase_next = b[7] ? PH_DELTA : PH_STATUS;
      end
    endcase

    if (emit) begin
      phase_next = PH_DELTA;
      delta_accum_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      running_status <= '0;
      current_status <= '0;
      delta_accum    <= '0;
      body_remaining <= '0;
      meta_type      <= '0;
      first_data     <= '0;
      meta_accum     <= '0;
      meta_index     <= '0;
      ev_valid       <= 1'b0;
    end else begin
      ev_valid <= in_valid && emit;
      if (in_valid) begin
        phase          <= phase_next;
        running_status <= running_status_next;
        current_status <= current_status_next;
        delta_accum    <= delta_accum_next;
        body_remaining <= body_remaining_next;
        meta_type      <= meta_type_next;
        first_data     <= first_data_next;
        meta_accum     <= meta_accum_next;
        meta_index     <= meta_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && emit)
      ev_item <= ev;
  end

endmodule
`default_nettype wire

### rtl/mtep_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Result queue between parser and consumer. Reports full early enough to
// absorb the one event still in the front's output register.
module mtep_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire mtep_pkg::out_item_t wr_item,
  input  wire logic                rd_en,
  output logic                     empty,
  output logic                     almost_full,
  output mtep_pkg::out_item_t      rd_item
);

  localparam int DEPTH = mtep_pkg::QDEPTH + 2;
  localparam int AW = $clog2(DEPTH);

  mtep_pkg::out_item_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          do_rd;

  assign do_rd = rd_en && (count != '0);
  assign empty = (count == '0);
  // two slots kept back; one of them absorbs the event in flight
  assign almost_full = (count >= (AW+1)'(DEPTH - 2));
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(wr_en) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wptr] <= wr_item;
  end

endmodule
`default_nettype wire

### rtl/midi_track_event_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// MIDI track event parser.
// Input channel: one byte of a track chunk body per beat (push/full), with
// track_start marking the first byte of a track (resets running status and
// parse state before that byte is read as a delta-time byte).
// Result channel: decoded events (empty/pop), oldest first.
// Throughput: one byte per cycle while full is low; the parser updates its
// state once for each byte it takes. An event passes through the parser's
// output register and then the queue before it appears on the result ports.
// A four-entry queue sits behind the parser's output register. When the
// consumer stops popping, full rises once two entries are taken, leaving
// room for the event still in flight; bytes are then held off until pops
// resume. Bytes that complete no event never need room but are held too.
// Reset (rst, synchronous): queue empty, parser expects a delta time,
// running status cleared.
module midi_track_event_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire mtep_pkg::in_item_t  in_data,
  output logic                     empty,
  input  wire logic                pop,
  output mtep_pkg::out_item_t      out_data
);

  logic                ev_valid;
  mtep_pkg::out_item_t ev_item;
  logic                accept;

  assign accept = push && !full;

  mtep_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_item  (in_data),
    .ev_valid (ev_valid),
    .ev_item  (ev_item)
  );

  mtep_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (ev_valid),
    .wr_item     (ev_item),
    .rd_en       (pop),
    .empty       (empty),
    .almost_full (full),
    .rd_item     (out_data)
  );

endmodule
`default_nettype wire

### rtl/mtep_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mtep_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire mtep_pkg::out_item_t out_data
);

  // results stay put while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_data))
    else $error("result changed while waiting");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_data.event_kind <= mtep_pkg::KIND_OTHER)
    else $error("bad event kind");

  a_chan: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.event_kind > mtep_pkg::KIND_BEND) |-> out_data.channel == 4'd0)
    else $error("channel set on non-voice event");

  a_rst: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not empty after reset");

endmodule

bind midi_track_event_parser mtep_checker u_chk (
  .clk(clk), .rst(rst), .full(full),
  .empty(empty), .pop(pop), .out_data(out_data)
);
`default_nettype wire

### tb/tb_midi_track_event_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_midi_track_event_parser;

  localparam int MAX_CYCLES = 400000;

  typedef enum logic [3:0] {
    ST_DELTA, ST_STATUS, ST_DATA1, ST_DATA2, ST_SX_LEN, ST_SX_BODY,
    ST_META_TYPE, ST_META_LEN, ST_META_BODY
  } parse_st_t;

  class event_scoreboard;
    parse_st_t   st;
    logic [7:0]  run_stat, cur_stat, meta_ty, data1;
    logic [31:0] delta, remain;
    logic [23:0] meta_acc;
    logic [2:0]  meta_idx;
    mtep_pkg::out_item_t pending[$];
    int          mismatches;

    function void clear_parse();
      st = ST_DELTA; run_stat = 0; cur_stat = 0; meta_ty = 0; data1 = 0;
      delta = 0; remain = 0; meta_acc = 0; meta_idx = 0;
    endfunction

    function void post_event(logic [3:0] kind, logic [3:0] ch, logic [6:0] key,
                             logic [7:0] val, logic [13:0] bnd, logic [23:0] mv);
      mtep_pkg::out_item_t e;
      e.event_kind = kind; e.channel = ch; e.key_or_number = key;
      e.value = val; e.bend = bnd; e.meta_value = mv; e.delta_ticks = delta;
      pending.push_back(e);
      st = ST_DELTA;
      delta = 0;
    endfunction

    function void finish_voice(logic [7:0] d1, logic [7:0] d2);
      logic [3:0] ch;
      logic [6:0] k, v;
      ch = cur_stat[3:0]; k = d1[6:0]; v = d2[6:0];
      case (cur_stat[7:4])
        4'h8: post_event(mtep_pkg::KIND_OFF, ch, k, {1'b0, v}, 0, 0);
        4'h9: post_event((v != 0) ? mtep_pkg::KIND_ON : mtep_pkg::KIND_OFF,
                         ch, k, {1'b0, v}, 0, 0);
        4'hA: post_event(mtep_pkg::KIND_KEYPRESS, ch, k, {1'b0, v}, 0, 0);
        4'hB: post_event(mtep_pkg::KIND_CTRL, ch, k, {1'b0, v}, 0, 0);
        4'hC: post_event(mtep_pkg::KIND_PROG, ch, 0,
                         (ch == 4'd9) ? {1'b1, k} : {1'b0, k}, 0, 0);
        4'hD: post_event(mtep_pkg::KIND_CHANPRESS, ch, 0, d1, 0, 0);
        default: post_event(mtep_pkg::KIND_BEND, ch, 0, 0, {v, k}, 0);
      endcase
    endfunction

    function void first_data(logic [7:0] b);
      data1 = b;
      if (cur_stat[7:4] == 4'hC || cur_stat[7:4] == 4'hD) finish_voice(b, 0);
      else st = ST_DATA2;
    endfunction

    function void finish_meta();
      case (meta_ty)
        mtep_pkg::META_EOT:
          post_event(mtep_pkg::KIND_EOT, 0, meta_ty[6:0], 0, 0, 0);
        mtep_pkg::META_TEMPO:
          post_event(mtep_pkg::KIND_TEMPO, 0, meta_ty[6:0], 0, 0, meta_acc);
        mtep_pkg::META_TIMESIG:
          post_event(mtep_pkg::KIND_TIMESIG, 0, meta_ty[6:0], 0, 0, meta_acc);
        mtep_pkg::META_PORT:
          post_event(mtep_pkg::KIND_PORT, 0, meta_ty[6:0], 0, 0, meta_acc);
        default:
          post_event(mtep_pkg::KIND_META, 0, meta_ty[6:0], 0, 0, 0);
      endcase
    endfunction

    function void note_byte(mtep_pkg::in_item_t it);
      logic [7:0] b;
      b = it.data_byte;
      if (it.track_start) clear_parse();
      case (st)
        ST_STATUS: begin
          if (!b[7]) begin
            if (run_stat != 0) begin
              cur_stat = run_stat;
              first_data(b);
            end else begin
              cur_stat = b;
              post_event(mtep_pkg::KIND_OTHER, 0, 0, 0, 0, 0);
            end
          end else begin
            cur_stat = b;
            if (b < 8'hF0) begin
              run_stat = b;
              st = ST_DATA1;
            end else if (b == 8'hF0 || b == 8'hF7) begin
              run_stat = 0; remain = 0; st = ST_SX_LEN;
            end else if (b == 8'hFF) st = ST_META_TYPE;
            else post_event(mtep_pkg::KIND_OTHER, 0, 0, 0, 0, 0);
          end
        end
        ST_DATA1: first_data(b);
        ST_DATA2: finish_voice(data1, b);
        ST_SX_LEN: begin
          remain = (remain << 7) + b[6:0];
          if (!b[7]) begin
            if (remain == 0) post_event(mtep_pkg::KIND_SYSEX, 0, 0, 0, 0, 0);
            else st = ST_SX_BODY;
          end
        end
        ST_SX_BODY: begin
          remain--;
          if (remain == 0) post_event(mtep_pkg::KIND_SYSEX, 0, 0, 0, 0, 0);
        end
        ST_META_TYPE: begin
          meta_ty = b; remain = 0; meta_acc = 0; meta_idx = 0; st = ST_META_LEN;
        end
        ST_META_LEN: begin
          remain = (remain << 7) + b[6:0];
          if (!b[7]) begin
            if (remain == 0) finish_meta();
            else st = ST_META_BODY;
          end
        end
        ST_META_BODY: begin
          if (meta_ty == mtep_pkg::META_TEMPO && meta_idx < 3)
            meta_acc = {meta_acc[15:0], b};
          else if (meta_ty == mtep_pkg::META_TIMESIG && meta_idx == 2)
            meta_acc = {16'd0, b};
          else if (meta_ty == mtep_pkg::META_PORT && meta_idx == 0)
            meta_acc = {16'd0, b};
          if (meta_idx < 7) meta_idx++;
          remain--;
          if (remain == 0) finish_meta();
        end
        default: begin
          delta = (delta << 7) + b[6:0];
          st = b[7] ? ST_DELTA : ST_STATUS;
        end
      endcase
    endfunction

    function void check_event(mtep_pkg::out_item_t got);
      mtep_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic      clk = 0, rst = 1, push = 0, pop = 0;
  logic      full, empty;
  mtep_pkg::in_item_t  in_data = '0;
  mtep_pkg::out_item_t out_data;

  event_scoreboard sb = new();
  int  cycles = 0;
  int  hold_cycles = 0;
  bit  calm = 0;
  bit  feeding_done = 0;
  int  sent = 0;

  midi_track_event_parser u_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb_midi_track_event_parser: FAIL");
      $finish;
    end
  end

  // result side: random pops, plus one long hold-off
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_event(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 25);
    end
  end

  task automatic send_byte(logic [7:0] b, bit ts = 0);
    while (!calm && $urandom_range(99) < 25) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_data <= '{data_byte: b, track_start: ts};
    do @(posedge clk); while (full);
    sb.note_byte('{data_byte: b, track_start: ts});
    sent++;
  endtask

  task automatic send_delta();
    int n;
    n = $urandom_range(3);
    case ($urandom_range(3))
      0: send_byte(8'h00);
      1: begin
        repeat (n) send_byte(8'h80 | 8'($urandom));
        send_byte(8'($urandom_range(127)));
      end
      2: begin
        repeat (4) send_byte(8'hFF);
        send_byte(8'h7F);
      end
      default: send_byte(8'($urandom_range(127)));
    endcase
  endtask

  task automatic send_len(int len);
    if (len > 127) send_byte(8'h80 | 8'(len >> 7));
    send_byte(8'(len & 127));
  endtask

  task automatic send_event();
    int r, len;
    logic [7:0] st, mt;
    r = $urandom_range(99);
    if (r < 55) begin
      st = {1'b1, 3'($urandom), 4'($urandom)};
      if ($urandom_range(2) != 0) send_byte(st);
      send_byte(8'($urandom));
      if (st[6:4] != 3'h4 && st[6:4] != 3'h5) send_byte(8'($urandom));
    end else if (r < 75) begin
      case ($urandom_range(5))
        0: mt = mtep_pkg::META_EOT;
        1: mt = mtep_pkg::META_TEMPO;
        2: mt = mtep_pkg::META_TIMESIG;
        3: mt = mtep_pkg::META_PORT;
        default: mt = 8'($urandom);
      endcase
      len = ($urandom_range(20) == 0) ? $urandom_range(200) : $urandom_range(6);
      send_byte(8'hFF);
      send_byte(mt);
      send_len(len);
      repeat (len) send_byte(8'($urandom));
    end else if (r < 85) begin
      len = $urandom_range(5);
      send_byte($urandom_range(1) ? 8'hF0 : 8'hF7);
      send_len(len);
      repeat (len) send_byte(8'($urandom));
    end else if (r < 92) begin
      send_byte(8'($urandom_range(8'hF1, 8'hFE)));
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed: no running status, voice extremes, metas, sysex, system codes
    send_byte(8'h00, 1); send_byte(8'h45);
    send_byte(8'h00); send_byte(8'h90); send_byte(8'hFF); send_byte(8'h00);
    send_byte(8'h81); send_byte(8'h00); send_byte(8'h7F); send_byte(8'h40);
    send_byte(8'h00); send_byte(8'hC9); send_byte(8'h7F);
    send_byte(8'h00); send_byte(8'hDF); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'hEF); send_byte(8'h7F); send_byte(8'h7F);
    send_byte(8'h00); send_byte(8'hF0); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h12);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h51); send_byte(8'h02);
    send_byte(8'hAB); send_byte(8'hCD);
    send_byte(8'h00); send_byte(8'hF8);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00);
    // long hold-off on the result side while bytes keep coming
    hold_cycles = 300;
    calm = 1;
    repeat (120) begin
      send_delta();
      send_event();
    end
    calm = 0;
    while (sent < 1000) begin
      if ($urandom_range(40) == 0) send_byte(8'($urandom), 1);
      else send_delta();
      send_event();
    end
    push <= 0;
    feeding_done = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_midi_track_event_parser: PASS");
    else
      $display("tb_midi_track_event_parser: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
